// ===== sv/lapm_pkg.sv =====
// Shared types, constants and helpers for the LED arc position marker.
package lapm_pkg;

    // Arc geometry
    localparam int MAX_ARC   = 32;
    localparam int STEP_W    = $clog2(MAX_ARC);
    localparam int LEN_W     = STEP_W + 1;

    // Fixed-point widths
    localparam int POS_W     = 18;
    localparam int Q16_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int MUL_B_W   = 9;
    localparam int PROD_W    = Q16_W + MUL_B_W;
    localparam int CENTER_W  = FRAC_W + STEP_W;
    localparam int RGB_W     = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int TIME_W    = 32;
    localparam int BLINK_W   = 16;

    localparam logic [Q16_W-1:0]  ONE_Q16   = Q16_W'(65536);
    localparam logic [PROD_W-1:0] ROUND_Q16 = PROD_W'(32768);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARC_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIP_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIP_COLOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 3'd6;

    // Smooth-mode taps
    localparam logic [1:0] TAP_NEAR = 2'd0;
    localparam logic [1:0] TAP_FAR  = 2'd1;
    localparam logic [1:0] TAP_TAIL_LO = 2'd2;
    localparam logic [1:0] TAP_TAIL_HI = 2'd3;

    // Pixel multiply phases
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_STORE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_CENTER,
        S_SPLIT,
        S_TAP,
        S_TAPK,
        S_MUL,
        S_PUSH,
        S_QRUN,
        S_FINISH
    } lapm_state_t;

    // Status of the blink divider
    typedef struct packed {
        logic busy;
        logic done;
        logic odd;
    } lapm_div_stat_t;

    // Pick one 8-bit channel out of a packed colour: 0 blue, 1 green, 2 red
    function automatic logic [7:0] chan_sel(input logic [RGB_W-1:0] rgb, input logic [1:0] ch);
        logic [7:0] res;
        case (ch)
            2'd0:    res = rgb[7:0];
            2'd1:    res = rgb[15:8];
            2'd2:    res = rgb[23:16];
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/lapm_div.sv =====
// Iterative restoring divider that reports the parity of the quotient.
module lapm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lapm_pkg::TIME_W-1:0]    dividend,
    input  logic [lapm_pkg::BLINK_W-1:0]   divisor,
    output lapm_pkg::lapm_div_stat_t       stat
);
    import lapm_pkg::*;

    localparam int CNT_W = $clog2(TIME_W);

    logic [BLINK_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               odd_reg, odd_next;

    logic [BLINK_W:0]   shifted;
    logic [BLINK_W:0]   diff;
    logic               ge;

    // One quotient bit per cycle, MSB first
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[TIME_W-1]};
        diff      = shifted - {1'b0, divisor};
        ge        = (shifted >= {1'b0, divisor});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        odd_next  = odd_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[BLINK_W-1:0] : shifted[BLINK_W-1:0];
            dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                odd_next  = ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        odd_reg <= odd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.odd  = odd_reg;

endmodule

// ===== sv/led_arc_position_marker.sv =====
// Top level of the LED arc position marker: registers, sequencer, shared multiplier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_stall  | position, time_ms
//  out     | output    | out_valid / out_stall| led_step, red, green, blue, last
//  cfg     | input     | cfg_wen              | cfg_index, cfg_data
//
//  One item at a time. The blink divider runs when blinking is on, then the background
//  fill writes each arc step when a background colour is set, then the centre is found.
//  Smooth mode: a drawn tap over a tint takes six products per pixel on the shared
//  17x9 multiplier; quantised mode writes each marker LED in turn; a finish step ends
//  the item.
//  Reset clears the sequencer and loads register defaults (pip_width 1, others 0).
//  A stalled output holds the output register and one pending item; the sequencer
//  waits on them, so out_stall stretches the item time.
module led_arc_position_marker (
    input  logic                              clk,
    input  logic                              rst_n,
    // config
    input  logic                              cfg_wen,
    input  logic [lapm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lapm_pkg::CFG_W-1:0]        cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [lapm_pkg::POS_W-1:0] position,
    input  logic [lapm_pkg::TIME_W-1:0]       time_ms,
    // output items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lapm_pkg::STEP_W-1:0]       led_step,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              last
);
    import lapm_pkg::*;

    // Configuration registers
    logic [5:0]         arc_length_reg;
    logic [5:0]         pip_width_reg;
    logic               smooth_mode_reg;
    logic [8:0]         tail_weight_reg;
    logic [RGB_W-1:0]   pip_color_reg;
    logic [RGB_W-1:0]   bg_color_reg;
    logic [BLINK_W-1:0] blink_half_reg;

    // Sequencer and datapath
    lapm_state_t         state_reg, state_next;
    logic [Q16_W-1:0]    v_reg, v_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [CENTER_W-1:0] center_reg, center_next;
    logic [1:0]          tap_reg, tap_next;
    logic [Q16_W-1:0]    k_reg, k_next;
    logic [1:0]          ch_reg, ch_next;
    logic [1:0]          ph_reg, ph_next;
    logic [RGB_W-1:0]    rgb_reg, rgb_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STEP_W-1:0]   run_last_reg, run_last_next;
    logic [STEP_W-1:0]   pix_step_reg, pix_step_next;

    // Pending item and output register
    logic                pend_valid_reg, pend_valid_next;
    logic [STEP_W-1:0]   pend_step_reg, pend_step_next;
    logic [RGB_W-1:0]    pend_rgb_reg, pend_rgb_next;
    logic                out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]   out_step_reg, out_step_next;
    logic [RGB_W-1:0]    out_rgb_reg, out_rgb_next;
    logic                out_last_reg, out_last_next;

    // Control
    logic                accept;
    logic                out_free;
    logic                can_push;
    logic                push;
    logic                flush;
    logic [STEP_W-1:0]   cand_step;
    logic [RGB_W-1:0]    cand_rgb;
    logic                div_start;
    lapm_div_stat_t      div_stat;

    // Shared multiplier
    logic [Q16_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;

    // Derived values
    logic [LEN_W-1:0]          len_clamped;
    logic [Q16_W-1:0]          v_sat;
    logic [Q16_W-1:0]          frac_ext;
    logic [Q16_W-1:0]          near;
    logic [STEP_W-1:0]         ci;
    logic signed [STEP_W+1:0]  tap_step;
    logic                      tap_in_arc;
    logic [PROD_W-9:0]         tail_k;
    logic [Q16_W-1:0]          tap_k;
    logic                      tap_ok;
    logic                      taps_done;
    logic                      bg_on;
    logic                      smooth_sel;
    logic [PROD_W-1:0]         rounded;
    logic [CENTER_W:0]         cs_sum;
    logic [LEN_W-1:0]          cs_raw;
    logic [STEP_W-1:0]         cs;
    logic signed [7:0]         run_first;
    logic signed [7:0]         run_end;
    logic signed [7:0]         run_first_c;
    logic signed [7:0]         run_end_c;
    logic signed [7:0]         len_s;
    logic                      run_empty;

    lapm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (time_ms),
        .divisor  (blink_half_reg),
        .stat     (div_stat)
    );

    assign prod = {{MUL_B_W{1'b0}}, mul_a} * {{Q16_W{1'b0}}, mul_b};

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_length_reg  <= '0;
            pip_width_reg   <= 6'd1;
            smooth_mode_reg <= 1'b0;
            tail_weight_reg <= '0;
            pip_color_reg   <= '0;
            bg_color_reg    <= '0;
            blink_half_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ARC_LENGTH:  arc_length_reg  <= cfg_data[5:0];
                REG_PIP_WIDTH:   pip_width_reg   <= cfg_data[5:0];
                REG_SMOOTH_MODE: smooth_mode_reg <= cfg_data[0];
                REG_TAIL_WEIGHT: tail_weight_reg <= cfg_data[8:0];
                REG_PIP_COLOR:   pip_color_reg   <= cfg_data[RGB_W-1:0];
                REG_BG_COLOR:    bg_color_reg    <= cfg_data[RGB_W-1:0];
                REG_BLINK_HALF:  blink_half_reg  <= cfg_data[BLINK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Handshake helpers and derived values
    always_comb
    begin
        accept   = in_valid && (state_reg == S_IDLE);
        out_free = !out_valid_reg || !out_stall;
        can_push = !pend_valid_reg || out_free;
        bg_on    = (bg_color_reg != '0);
        smooth_sel = smooth_mode_reg && (pip_width_reg <= 6'd1);

        len_clamped = (arc_length_reg > 6'(MAX_ARC)) ? LEN_W'(MAX_ARC) : LEN_W'(arc_length_reg);

        // saturate position to 0..1.0
        if (position < 0)
            v_sat = '0;
        else if (position > $signed(POS_W'(65536)))
            v_sat = ONE_Q16;
        else
            v_sat = position[Q16_W-1:0];

        // smooth taps
        ci       = center_reg[CENTER_W-1:FRAC_W];
        frac_ext = {1'b0, center_reg[FRAC_W-1:0]};
        near     = ONE_Q16 - frac_ext;
        case (tap_reg)
            TAP_NEAR:    tap_step = $signed({2'b00, ci});
            TAP_FAR:     tap_step = $signed({2'b00, ci}) + 7'sd1;
            TAP_TAIL_LO: tap_step = $signed({2'b00, ci}) - 7'sd1;
            TAP_TAIL_HI: tap_step = $signed({2'b00, ci}) + 7'sd2;
            default:     tap_step = '0;
        endcase
        tap_in_arc = (tap_step >= 0) && (tap_step < $signed({1'b0, len_reg}));
        tail_k     = acc_reg[PROD_W-1:8];
        case (tap_reg)
            TAP_NEAR: tap_k = near;
            TAP_FAR:  tap_k = frac_ext;
            default:  tap_k = (tail_k > {1'b0, ONE_Q16}) ? ONE_Q16 : tail_k[Q16_W-1:0];
        endcase
        tap_ok    = tap_in_arc && (tap_k != '0);
        taps_done = (tap_reg == TAP_TAIL_HI) || ((tap_reg == TAP_FAR) && (tail_weight_reg == '0));

        // rounding of an accumulated channel
        rounded = acc_reg + ROUND_Q16;

        // quantised run from the centre product
        cs_sum = {1'b0, acc_reg[CENTER_W-1:0]} + (CENTER_W+1)'(32768);
        cs_raw = cs_sum[CENTER_W:FRAC_W];
        cs     = (cs_raw >= len_reg) ? STEP_W'(len_reg - 1'b1) : cs_raw[STEP_W-1:0];
        len_s  = $signed({2'b00, len_reg});
        run_first   = $signed({3'b000, cs}) - $signed({3'b000, pip_width_reg[5:1]});
        run_end     = run_first + $signed({2'b00, pip_width_reg}) - 8'sd1;
        run_first_c = (run_first < 0) ? 8'sd0 : run_first;
        run_end_c   = (run_end >= len_s) ? (len_s - 8'sd1) : run_end;
        run_empty   = (run_end < 0) || (run_end_c < run_first_c);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (len_clamped != '0))
                    state_next = (blink_half_reg != '0) ? S_DIV : S_FILL;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = div_stat.odd ? S_IDLE : S_FILL;
            end
            S_FILL:
            begin
                if (!bg_on)
                    state_next = S_CENTER;
                else if (can_push && (step_reg == STEP_W'(len_reg - 1'b1)))
                    state_next = S_CENTER;
            end
            S_CENTER: state_next = S_SPLIT;
            S_SPLIT:
            begin
                if (smooth_sel)
                    state_next = S_TAP;
                else
                    state_next = run_empty ? S_FINISH : S_QRUN;
            end
            S_TAP: state_next = S_TAPK;
            S_TAPK:
            begin
                if (tap_ok)
                    state_next = S_MUL;
                else
                    state_next = taps_done ? S_FINISH : S_TAP;
            end
            S_MUL:
            begin
                if ((ph_reg == PH_STORE) && (ch_reg == 2'd2))
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (can_push)
                    state_next = taps_done ? S_FINISH : S_TAP;
            end
            S_QRUN:
            begin
                if (can_push && (step_reg == run_last_reg))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: pushes, flush, multiplier operands, divider start
    always_comb
    begin
        push      = 1'b0;
        flush     = 1'b0;
        cand_step = step_reg;
        cand_rgb  = bg_color_reg;
        mul_a     = '0;
        mul_b     = '0;
        div_start = accept && (len_clamped != '0) && (blink_half_reg != '0);
        case (state_reg)
            S_FILL:
            begin
                push = bg_on && can_push;
            end
            S_CENTER:
            begin
                mul_a = v_reg;
                mul_b = MUL_B_W'(len_reg - 1'b1);
            end
            S_TAP:
            begin
                mul_a = (tap_reg == TAP_TAIL_LO) ? near : frac_ext;
                mul_b = tail_weight_reg;
            end
            S_MUL:
            begin
                if ((ph_reg == PH_FIRST) && bg_on)
                begin
                    mul_a = ONE_Q16 - k_reg;
                    mul_b = {1'b0, chan_sel(bg_color_reg, ch_reg)};
                end
                else
                begin
                    mul_a = k_reg;
                    mul_b = {1'b0, chan_sel(pip_color_reg, ch_reg)};
                end
            end
            S_PUSH:
            begin
                push      = can_push;
                cand_step = pix_step_reg;
                cand_rgb  = rgb_reg;
            end
            S_QRUN:
            begin
                push     = can_push;
                cand_rgb = pip_color_reg;
            end
            S_FINISH:
            begin
                flush = pend_valid_reg && out_free;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        v_next        = v_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        center_next   = center_reg;
        tap_next      = tap_reg;
        k_next        = k_reg;
        ch_next       = ch_reg;
        ph_next       = ph_reg;
        rgb_next      = rgb_reg;
        step_next     = step_reg;
        run_last_next = run_last_reg;
        pix_step_next = pix_step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next    = v_sat;
                    len_next  = len_clamped;
                    step_next = '0;
                end
            end
            S_FILL:
            begin
                if (push)
                    step_next = step_reg + 1'b1;
            end
            S_CENTER: acc_next = prod;
            S_SPLIT:
            begin
                center_next   = acc_reg[CENTER_W-1:0];
                tap_next      = TAP_NEAR;
                step_next     = run_first_c[STEP_W-1:0];
                run_last_next = run_end_c[STEP_W-1:0];
            end
            S_TAP: acc_next = prod;
            S_TAPK:
            begin
                k_next        = tap_k;
                pix_step_next = tap_step[STEP_W-1:0];
                ch_next       = '0;
                ph_next       = PH_FIRST;
                if (!tap_ok)
                    tap_next = tap_reg + 1'b1;
            end
            S_MUL:
            begin
                case (ph_reg)
                    PH_FIRST:
                    begin
                        acc_next = prod;
                        ph_next  = bg_on ? PH_SECOND : PH_STORE;
                    end
                    PH_SECOND:
                    begin
                        acc_next = acc_reg + prod;
                        ph_next  = PH_STORE;
                    end
                    default:
                    begin
                        case (ch_reg)
                            2'd0:    rgb_next[7:0]   = rounded[23:16];
                            2'd1:    rgb_next[15:8]  = rounded[23:16];
                            default: rgb_next[23:16] = rounded[23:16];
                        endcase
                        ch_next = ch_reg + 1'b1;
                        ph_next = PH_FIRST;
                    end
                endcase
            end
            S_PUSH:
            begin
                if (push)
                    tap_next = tap_reg + 1'b1;
            end
            S_QRUN:
            begin
                if (push)
                    step_next = step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Pending item and output register: one item held back to flag the last one
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_step_next  = pend_step_reg;
        pend_rgb_next   = pend_rgb_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_step_next   = out_step_reg;
        out_rgb_next    = out_rgb_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_step_next  = pend_step_reg;
                out_rgb_next   = pend_rgb_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_step_next  = cand_step;
            pend_rgb_next   = cand_rgb;
        end
        else if (flush)
        begin
            out_valid_next  = 1'b1;
            out_step_next   = pend_step_reg;
            out_rgb_next    = pend_rgb_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        len_reg      <= len_next;
        acc_reg      <= acc_next;
        center_reg   <= center_next;
        tap_reg      <= tap_next;
        k_reg        <= k_next;
        ch_reg       <= ch_next;
        ph_reg       <= ph_next;
        rgb_reg      <= rgb_next;
        step_reg     <= step_next;
        run_last_reg <= run_last_next;
        pix_step_reg <= pix_step_next;
        pend_step_reg <= pend_step_next;
        pend_rgb_reg  <= pend_rgb_next;
        out_step_reg  <= out_step_next;
        out_rgb_reg   <= out_rgb_next;
        out_last_reg  <= out_last_next;
    end

    // Ports
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign led_step  = out_step_reg;
    assign red       = out_rgb_reg[23:16];
    assign green     = out_rgb_reg[15:8];
    assign blue      = out_rgb_reg[7:0];
    assign last      = out_last_reg;

    // Checks
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending item left over while idle");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the blink check");

    a_blend_needs_bg: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && (ph_reg == PH_SECOND)) |-> bg_on)
        else $error("blend phase without background colour");

    a_push_flush_excl: assert property (@(posedge clk) disable iff (!rst_n)
        flush |=> !pend_valid_reg)
        else $error("pending item survived the final flush");

endmodule
